@@ rtl/tpap_pkg.sv @@
// Shared types and constants for the TLV packet attribute parser.
`timescale 1ns / 1ps
`default_nettype none
package tpap_pkg;

    // Default width of the byte position counter
    localparam int OFFSET_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME    = 3'd4;

    // Reset values of the type codes
    localparam logic [7:0] RST_SESSION = 8'd1;
    localparam logic [7:0] RST_STATUS  = 8'd2;
    localparam logic [7:0] RST_PAYLOAD = 8'd3;
    localparam logic [7:0] RST_SIZE    = 8'd4;
    localparam logic [7:0] RST_NAME    = 8'd5;

    // Minimum value lengths for the code and size attributes
    localparam logic [15:0] CODE_LEN_MIN = 16'd1;
    localparam logic [15:0] SIZE_LEN_MIN = 16'd4;

    // Number of value bytes folded into the size word
    localparam logic [2:0] SIZE_BYTES = 3'd4;

    // Packed widths on the stream ports
    localparam int RES_TDATA_W = 120;

    // Attribute type codes from the configuration registers
    typedef struct packed {
        logic [7:0] session_code;
        logic [7:0] status_code;
        logic [7:0] payload_code;
        logic [7:0] size_code;
        logic [7:0] name_code;
    } t_codes;

    // One packet summary
    typedef struct packed {
        logic        truncated;
        logic [31:0] size_value;
        logic [7:0]  status_value;
        logic [15:0] payload_length;
        logic [15:0] payload_offset;
        logic [15:0] name_offset;
        logic [15:0] session_offset;
        logic [7:0]  packet_type;
        logic [7:0]  version;
    } t_result;

endpackage
`default_nettype wire

@@ rtl/tlv_packet_attribute_parser.sv @@
// Top level of the TLV packet attribute parser.
`timescale 1ns / 1ps
`default_nettype none
// Takes one packet byte per transfer on the slave stream, tlast on the
// packet's last byte, and sends one summary transfer per packet on the
// master stream once that summary is registered. The combinational parse
// state update handles each byte, so a byte can be taken every cycle; the
// result register plus one skid entry let the input keep flowing while a
// summary waits, and input stalls only when both hold a summary. Attribute
// type codes come from five 8-bit registers on the plain write port; the
// user must write them only while idle, which the block does not enforce.
module tlv_packet_attribute_parser #(
    parameter int OFFSET_BITS = tpap_pkg::OFFSET_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // slave stream
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [7:0]                         i_s_tdata,  // [7:0] packet_byte
    input  wire                                i_s_tlast,  // final_byte
    // master stream
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // [7:0] version, [15:8] packet_type, [31:16] session_offset,
    // [47:32] name_offset, [63:48] payload_offset, [79:64] payload_length,
    // [87:80] status_value, [119:88] size_value
    output logic [tpap_pkg::RES_TDATA_W-1:0]   o_m_tdata,
    output logic [0:0]                         o_m_tuser,  // [0] truncated
    // configuration writes
    input  wire                                i_cfg_we,
    input  wire  [tpap_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [7:0]                         i_cfg_wdata
);
    import tpap_pkg::*;

    t_codes  r_codes;
    logic    w_in_xfer;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;
    logic    w_space;

    // Type code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.session_code <= RST_SESSION;
            r_codes.status_code  <= RST_STATUS;
            r_codes.payload_code <= RST_PAYLOAD;
            r_codes.size_code    <= RST_SIZE;
            r_codes.name_code    <= RST_NAME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SESSION: r_codes.session_code <= i_cfg_wdata;
                CFG_STATUS:  r_codes.status_code  <= i_cfg_wdata;
                CFG_PAYLOAD: r_codes.payload_code <= i_cfg_wdata;
                CFG_SIZE:    r_codes.size_code    <= i_cfg_wdata;
                CFG_NAME:    r_codes.name_code    <= i_cfg_wdata;
                default:     r_codes              <= r_codes;
            endcase
        end
    end

    assign o_s_tready = w_space;
    assign w_in_xfer  = i_s_tvalid && w_space;

    tpap_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_xfer),
        .i_byte      (i_s_tdata),
        .i_final     (i_s_tlast),
        .i_codes     (r_codes),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    tpap_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_space),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_out)
    );

    // Pack the summary fields, version in the lowest bits
    assign o_m_tdata = {w_out.size_value, w_out.status_value, w_out.payload_length,
                        w_out.payload_offset, w_out.name_offset, w_out.session_offset,
                        w_out.packet_type, w_out.version};
    assign o_m_tuser = w_out.truncated;

endmodule
`default_nettype wire

@@ rtl/tpap_parser.sv @@
// Per-byte parse state and attribute capture for one packet.
`timescale 1ns / 1ps
`default_nettype none
module tpap_parser #(
    parameter int OFFSET_BITS = tpap_pkg::OFFSET_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire  [7:0]              i_byte,
    input  wire                     i_final,
    input  wire  tpap_pkg::t_codes  i_codes,
    output logic                    o_res_valid,
    output tpap_pkg::t_result       o_res
);
    import tpap_pkg::*;

    // Position counter is widened to at least 16 bits for offset math
    localparam int PW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

    typedef enum logic [5:0] {
        PH_VERSION = 6'b000001,
        PH_PTYPE   = 6'b000010,
        PH_ATYPE   = 6'b000100,
        PH_LENHI   = 6'b001000,
        PH_LENLO   = 6'b010000,
        PH_VALUE   = 6'b100000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [7:0]             r_type, n_type;
    logic [15:0]            r_len, n_len;
    logic [15:0]            r_rem, n_rem;
    logic [2:0]             r_vi, n_vi;
    logic [31:0]            r_sa, n_sa;
    logic                   r_stopped, n_stopped;
    t_result                r_held, n_held;

    logic                   w_pos_max;
    logic [PW-1:0]          w_pos_ext;
    logic [15:0]            w_pos16;
    logic                   w_take;
    logic [15:0]            w_start;

    assign w_pos_max = &r_pos;
    assign w_pos_ext = PW'(r_pos);
    assign w_pos16   = w_pos_ext[15:0];

    // Next parse state for the byte on the input
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_type    = r_type;
        n_len     = r_len;
        n_rem     = r_rem;
        n_vi      = r_vi;
        n_sa      = r_sa;
        n_stopped = r_stopped;
        n_held    = r_held;
        w_take    = 1'b0;
        w_start   = 16'd0;

        if (!r_stopped) begin
            if (!(r_phase == PH_VERSION || r_phase == PH_PTYPE) && w_pos_max) begin
                // attribute byte at the saturated position
                n_stopped        = 1'b1;
                n_held.truncated = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_VERSION: begin
                        n_held.version = i_byte;
                        n_phase        = PH_PTYPE;
                    end
                    PH_PTYPE: begin
                        n_held.packet_type = i_byte;
                        n_phase            = PH_ATYPE;
                    end
                    PH_ATYPE: begin
                        n_type  = i_byte;
                        n_phase = PH_LENHI;
                        if (i_final) begin
                            n_stopped        = 1'b1;
                            n_held.truncated = 1'b1;
                        end
                    end
                    PH_LENHI: begin
                        n_len   = {i_byte, 8'h00};
                        n_phase = PH_LENLO;
                        if (i_final) begin
                            n_stopped        = 1'b1;
                            n_held.truncated = 1'b1;
                        end
                    end
                    PH_LENLO: begin
                        n_len = {r_len[15:8], i_byte};
                        n_rem = {r_len[15:8], i_byte};
                        n_vi  = 3'd0;
                        n_sa  = 32'd0;
                        if ({r_len[15:8], i_byte} == 16'd0) begin
                            // empty value: offset is just past the header
                            w_take  = 1'b1;
                            w_start = w_pos16 + 16'd1;
                            n_phase = PH_ATYPE;
                        end else if (i_final) begin
                            n_stopped        = 1'b1;
                            n_held.truncated = 1'b1;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (r_vi < SIZE_BYTES) begin
                            n_sa = {r_sa[23:0], i_byte};
                            n_vi = r_vi + 3'd1;
                        end
                        n_rem = r_rem - 16'd1;
                        if (r_rem == 16'd1) begin
                            w_take  = 1'b1;
                            w_start = w_pos16 + 16'd1 - r_len;
                            n_phase = PH_ATYPE;
                        end else if (i_final) begin
                            n_stopped        = 1'b1;
                            n_held.truncated = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_VERSION;
                    end
                endcase
            end
        end

        // Record a complete attribute; every matching code applies
        if (w_take) begin
            if (r_type == i_codes.session_code) begin
                n_held.session_offset = w_start;
            end
            if (r_type == i_codes.name_code) begin
                n_held.name_offset = w_start;
            end
            if (r_type == i_codes.payload_code) begin
                n_held.payload_offset = w_start;
                n_held.payload_length = n_len;
            end
            if (r_type == i_codes.status_code && n_len >= CODE_LEN_MIN) begin
                // first value byte sits at the top of the filled part of the shifted word
                unique case (n_vi)
                    3'd1:    n_held.status_value = n_sa[7:0];
                    3'd2:    n_held.status_value = n_sa[15:8];
                    3'd3:    n_held.status_value = n_sa[23:16];
                    3'd4:    n_held.status_value = n_sa[31:24];
                    default: n_held.status_value = r_held.status_value;
                endcase
            end
            if (r_type == i_codes.size_code && n_len >= SIZE_LEN_MIN) begin
                n_held.size_value = n_sa;
            end
        end

        // Saturating byte position
        if (!w_pos_max) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Summary leaves on the final byte
    assign o_res_valid = i_valid && i_final;
    assign o_res       = n_held;

    // State registers; the final byte starts a new packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_final)) begin
            r_phase   <= PH_VERSION;
            r_pos     <= '0;
            r_type    <= 8'd0;
            r_len     <= 16'd0;
            r_rem     <= 16'd0;
            r_vi      <= 3'd0;
            r_sa      <= 32'd0;
            r_stopped <= 1'b0;
            r_held    <= '0;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_vi      <= n_vi;
            r_sa      <= n_sa;
            r_stopped <= n_stopped;
            r_held    <= n_held;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tpap_out_buf.sv @@
// Result register with a skid entry toward the output stream.
`timescale 1ns / 1ps
`default_nettype none
module tpap_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire tpap_pkg::t_result i_res,
    output logic                o_space,
    output logic                o_valid,
    input  wire                 i_ready,
    output tpap_pkg::t_result   o_res
);
    import tpap_pkg::*;

    logic    r_main_vld, n_main_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    w_pop;
    logic    w_main_free;

    assign w_pop       = r_main_vld && i_ready;
    assign w_main_free = !r_main_vld || w_pop;

    // Main entry refills from the skid first, then from a new result
    always_comb begin
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        n_main     = r_main;
        n_skid     = r_skid;
        if (w_main_free) begin
            if (r_skid_vld) begin
                n_main     = r_skid;
                n_main_vld = 1'b1;
                n_skid     = i_res;
                n_skid_vld = i_push;
            end else begin
                n_main     = i_res;
                n_main_vld = i_push;
            end
        end else if (i_push) begin
            n_skid     = i_res;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_space = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_res   = r_main;

endmodule
`default_nettype wire

@@ rtl/tpap_checker.sv @@
// Port-level checks for the TLV packet attribute parser, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module tpap_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_s_tvalid,
    input wire         o_s_tready,
    input wire         i_s_tlast,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [119:0] o_m_tdata,
    input wire [0:0]   o_m_tuser
);

    // A summary appears only after a transfer of a packet's last byte
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("summary appeared without a last-byte transfer");

    // Input backpressure only while a summary is pending
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no pending summary");

    // Reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output not empty after reset");

    // A stalled summary holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled summary changed");

endmodule

bind tlv_packet_attribute_parser tpap_checker u_tpap_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

@@ verif/tlv_packet_attribute_parser_tb.sv @@
// Self-checking testbench for the TLV packet attribute parser.
`timescale 1ns / 1ps
module tlv_packet_attribute_parser_tb;
    import tpap_pkg::*;

    localparam int          WDOG_LIMIT   = 1000;  // cycles without any transfer
    localparam int          DRAIN_CYCLES = 8;     // extra wait after every summary is out
    localparam int          PHASE_BYTES  = 195;   // random bytes per phase, eight phases
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    // Parse phases of the predictor
    typedef enum logic [2:0] {
        PH_VERSION, PH_PTYPE, PH_ATYPE, PH_LENHI, PH_LENLO, PH_VALUE
    } t_phase;

    // One row of the directed table; exp is used only where typed is set
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        t_result    exp;
    } t_row;

    // Hand-written summaries: {truncated, 104 bits of attributes, packet_type, version}
    localparam t_result NO_EXP       = '0;
    localparam t_result EXP_ONE_BYTE = {1'b0, 104'd0, 8'h00, 8'hFF};
    localparam t_result EXP_CUT_TYPE = {1'b1, 104'd0, 8'hFF, 8'h00};
    localparam t_result EXP_CUT_LEN  = {1'b1, 104'd0, 8'h08, 8'h07};

    localparam t_row DIR_TAB [25] = '{
        // single-byte packet: version only
        {8'hFF, 1'b1, 1'b1, EXP_ONE_BYTE},
        // packet ends on an attribute type byte
        {8'h00, 1'b0, 1'b0, NO_EXP}, {8'hFF, 1'b0, 1'b0, NO_EXP},
        {8'h02, 1'b1, 1'b1, EXP_CUT_TYPE},
        // packet ends on the first length byte
        {8'h07, 1'b0, 1'b0, NO_EXP}, {8'h08, 1'b0, 1'b0, NO_EXP},
        {8'h04, 1'b0, 1'b0, NO_EXP}, {8'h00, 1'b1, 1'b1, EXP_CUT_LEN},
        // zero-length data, zero-length code, two-byte size, session value cut off
        {8'h01, 1'b0, 1'b0, NO_EXP}, {8'h02, 1'b0, 1'b0, NO_EXP},
        {8'h03, 1'b0, 1'b0, NO_EXP}, {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h02, 1'b0, 1'b0, NO_EXP}, {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h04, 1'b0, 1'b0, NO_EXP}, {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h02, 1'b0, 1'b0, NO_EXP}, {8'hFF, 1'b0, 1'b0, NO_EXP},
        {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h01, 1'b0, 1'b0, NO_EXP}, {8'h00, 1'b0, 1'b0, NO_EXP},
        {8'h03, 1'b0, 1'b0, NO_EXP}, {8'h5A, 1'b1, 1'b0, NO_EXP}
    };

    // DUT signals
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [RES_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
    logic [7:0]             cfg_wdata = '0;

    // Test control
    int      src_idle_pct  = 0;
    int      sink_stall_pct = 0;
    int      n_sent        = 0;
    int      n_fail        = 0;
    int      quiet_cycles  = 0;
    t_result summary_q [$];
    t_row    typed_q   [$];

    // Predictor state
    t_codes      p_codes;
    t_phase      p_phase;
    logic [15:0] p_pos, p_len, p_left;
    logic [7:0]  p_type;
    logic [2:0]  p_vidx;
    logic [31:0] p_asm;
    logic        p_halted;
    t_result     p_held;

    always #6 clk = ~clk;

    tlv_packet_attribute_parser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Per-packet state back to zero
    task automatic clear_parse();
        p_phase  = PH_VERSION;
        p_pos    = '0;
        p_len    = '0;
        p_left   = '0;
        p_type   = '0;
        p_vidx   = '0;
        p_asm    = '0;
        p_halted = 1'b0;
        p_held   = '0;
    endtask

    task automatic halt_parse();
        p_halted         = 1'b1;
        p_held.truncated = 1'b1;
    endtask

    // Record a complete attribute whose value starts at start
    task automatic take_attr(input logic [15:0] start);
        if (p_type == p_codes.session_code)
            p_held.session_offset = start;
        if (p_type == p_codes.name_code)
            p_held.name_offset = start;
        if (p_type == p_codes.payload_code) begin
            p_held.payload_offset = start;
            p_held.payload_length = p_len;
        end
        if (p_type == p_codes.status_code && p_len >= CODE_LEN_MIN &&
            p_vidx >= 3'd1 && p_vidx <= SIZE_BYTES)
            p_held.status_value = 8'(p_asm >> (8 * (int'(p_vidx) - 1)));
        if (p_type == p_codes.size_code && p_len >= SIZE_LEN_MIN)
            p_held.size_value = p_asm;
    endtask

    // Advance the parser by one byte; done is set with the summary on tlast
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output logic done, output t_result sum);
        done = 1'b0;
        sum  = '0;
        if (!p_halted) begin
            if (p_phase >= PH_ATYPE && p_pos == POS_MAX) begin
                halt_parse();
            end else begin
                case (p_phase)
                    PH_VERSION: begin
                        p_held.version = b;
                        p_phase        = PH_PTYPE;
                    end
                    PH_PTYPE: begin
                        p_held.packet_type = b;
                        p_phase            = PH_ATYPE;
                    end
                    PH_ATYPE: begin
                        p_type  = b;
                        p_phase = PH_LENHI;
                        if (last) halt_parse();
                    end
                    PH_LENHI: begin
                        p_len   = {b, 8'h00};
                        p_phase = PH_LENLO;
                        if (last) halt_parse();
                    end
                    PH_LENLO: begin
                        p_len[7:0] = b;
                        p_left     = p_len;
                        p_vidx     = '0;
                        p_asm      = '0;
                        if (p_len == 16'd0) begin
                            take_attr(p_pos + 16'd1);
                            p_phase = PH_ATYPE;
                        end else if (last) begin
                            halt_parse();
                        end else begin
                            p_phase = PH_VALUE;
                        end
                    end
                    default: begin
                        // first four value bytes feed the size/code word
                        if (p_vidx < SIZE_BYTES) begin
                            p_asm  = {p_asm[23:0], b};
                            p_vidx = p_vidx + 3'd1;
                        end
                        p_left = p_left - 16'd1;
                        if (p_left == 16'd0) begin
                            take_attr(p_pos + 16'd1 - p_len);
                            p_phase = PH_ATYPE;
                        end else if (last) begin
                            halt_parse();
                        end
                    end
                endcase
            end
        end
        if (p_pos != POS_MAX) p_pos = p_pos + 16'd1;
        if (last) begin
            done = 1'b1;
            sum  = p_held;
            clear_parse();
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, e, a);
            n_fail++;
        end
    endtask

    task automatic compare_summary(input t_result e, input t_result a);
        check_field("version", e.version, a.version);
        check_field("packet_type", e.packet_type, a.packet_type);
        check_field("session_offset", e.session_offset, a.session_offset);
        check_field("name_offset", e.name_offset, a.name_offset);
        check_field("payload_offset", e.payload_offset, a.payload_offset);
        check_field("payload_length", e.payload_length, a.payload_length);
        check_field("status_value", e.status_value, a.status_value);
        check_field("size_value", e.size_value, a.size_value);
        check_field("truncated", e.truncated, a.truncated);
    endtask

    initial clear_parse();

    // Monitor: predict on every input transfer, check every output transfer
    always @(posedge clk) begin
        logic    done;
        t_result sum;
        t_row    ov;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast, done, sum);
                if (done) begin
                    if (typed_q.size() != 0) begin
                        ov = typed_q.pop_front();
                        if (ov.typed) sum = ov.exp;
                    end
                    summary_q.push_back(sum);
                end
            end
            if (m_tvalid && m_tready) begin
                if (summary_q.size() == 0) begin
                    $display("%0t ns: unexpected summary: expected none, actual 0x%0h",
                             $time, {m_tuser, m_tdata});
                    n_fail++;
                end else begin
                    compare_summary(summary_q.pop_front(), {m_tuser, m_tdata});
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on cycles without any transfer
    initial begin
        while (quiet_cycles < WDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** tlv_packet_attribute_parser: FAILED **");
        $finish;
    end

    // One byte transfer; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic apply_codes(input t_codes c);
        cfg_write(CFG_SESSION, c.session_code);
        cfg_write(CFG_STATUS, c.status_code);
        cfg_write(CFG_PAYLOAD, c.payload_code);
        cfg_write(CFG_SIZE, c.size_code);
        cfg_write(CFG_NAME, c.name_code);
        cfg_we  <= 1'b0;
        p_codes = c;
    endtask

    // Wait until every summary is out and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_code();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
    endfunction

    // Mostly one of the configured types, sometimes anything
    function automatic logic [7:0] pick_type();
        case ($urandom_range(5))
            0: return p_codes.session_code;
            1: return p_codes.status_code;
            2: return p_codes.payload_code;
            3: return p_codes.size_code;
            4: return p_codes.name_code;
            default: return 8'($urandom);
        endcase
    endfunction

    // Well-formed packet with random content, or a short, noisy or cut one
    task automatic send_random_packet();
        logic [7:0]  pkt [$];
        logic [15:0] len;
        int          kind, nattr, nval, cut, r;
        bit          open_end;
        kind     = $urandom_range(99);
        open_end = 1'b0;
        if (kind < 5) begin
            pkt.push_back(8'($urandom));
        end else if (kind < 12) begin
            repeat ($urandom_range(2, 30)) pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(8'($urandom));
            pkt.push_back(8'($urandom));
            nattr = $urandom_range(0, 6);
            for (int a = 0; a < nattr && !open_end; a++) begin
                r = $urandom_range(99);
                if (r < 10)      len = 16'd0;
                else if (r < 75) len = 16'($urandom_range(1, 6));
                else if (r < 95) len = 16'($urandom_range(7, 24));
                else             len = 16'($urandom);
                nval = len;
                // long value: packet ends inside it
                if (len > 16'd24) begin
                    nval     = $urandom_range(0, 20);
                    open_end = 1'b1;
                end
                pkt.push_back(pick_type());
                pkt.push_back(len[15:8]);
                pkt.push_back(len[7:0]);
                repeat (nval) pkt.push_back(8'($urandom));
            end
            if ($urandom_range(99) < 15) begin
                cut = $urandom_range(1, pkt.size());
                while (pkt.size() > cut) void'(pkt.pop_back());
            end
        end
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Main sequence
    initial begin
        t_codes     c;
        logic [7:0] v;
        int         phase_end;
        p_codes = {RST_SESSION, RST_STATUS, RST_PAYLOAD, RST_SIZE, RST_NAME};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed packets under reset type codes
        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].last) typed_q.push_back(DIR_TAB[i]);
            send_byte(DIR_TAB[i].b, DIR_TAB[i].last);
        end

        // Random phases: idle mode cycles every four, new type codes each phase after the first
        for (int k = 0; k < 8; k++) begin
            case (k % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            if (k > 0) begin
                drain();
                case (k)
                    1: c = '0;
                    2: c = '1;
                    3: begin
                        v = 8'($urandom);
                        c = {5{v}};
                    end
                    default: c = {rand_code(), rand_code(), rand_code(), rand_code(), rand_code()};
                endcase
                apply_codes(c);
            end
            phase_end = n_sent + PHASE_BYTES;
            while (n_sent < phase_end) send_random_packet();
        end

        drain();
        if (n_fail == 0)
            $display("** tlv_packet_attribute_parser: PASSED **");
        else
            $display("** tlv_packet_attribute_parser: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tpap_pkg.sv
rtl/tpap_parser.sv
rtl/tpap_out_buf.sv
rtl/tlv_packet_attribute_parser.sv
rtl/tpap_checker.sv
verif/tlv_packet_attribute_parser_tb.sv
